// File: rtl/assert_macros.svh
// Assertion macros shared by the thermistor conversion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/tbt_pkg.sv
// Types, constants and helper functions for the thermistor conversion pipeline.
package tbt_pkg;

   localparam int ADC_BITS_DEF = 10;
   localparam int LOG_W        = 20;
   localparam int FRAC_W       = 24;
   localparam int LOG_STEPS    = 24;
   localparam int DIV_STEPS    = 24;
   localparam int DD_W         = 48;
   localparam int TC_W         = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 20;

   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [TC_W-1:0] TC_CAP = 24'd10000000;
   localparam logic [31:0] RECIP5    = 32'hCCCCCCCD;
   localparam int ZERO_C_CK   = 27315;
   localparam int F_OFFSET    = 3200;
   localparam int OUT_MAX     = 100000;
   localparam int OUT_MIN     = -100000;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_BETA    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_R0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_T0      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RB      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULLUP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT    = 3'd5;

   // Output unit codes
   localparam logic [1:0] UNIT_KELVIN  = 2'd0;
   localparam logic [1:0] UNIT_CELSIUS = 2'd1;
   localparam logic [1:0] UNIT_FAHR    = 2'd2;

   typedef struct packed {
      logic valid;
      logic bad;
   } tbt_ctl_type;

   // One operand of the log2 chain: exponent, mantissa and fraction bits so far
   typedef struct packed {
      logic [4:0]        e;
      logic [31:0]       m;
      logic [FRAC_W-1:0] f;
   } tbt_log_type;

   // One item in the division chain
   typedef struct packed {
      logic [DD_W-1:0] rem;
      logic [TC_W-1:0] xlo;
      logic [TC_W-1:0] q;
      logic [DD_W-1:0] dvs;
      logic            cap;
   } tbt_div_type;

   // Find the top set bit and left-align the value as a Q1.31 mantissa.
   function automatic tbt_log_type log_norm(input logic [LOG_W-1:0] x);
      tbt_log_type r;
      logic [4:0]  e;
      e = 5'd0;
      for (int i = 0; i < LOG_W; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      r.e = e;
      r.m = 32'(x) << (5'd31 - e);
      r.f = '0;
      return r;
   endfunction

endpackage

// File: rtl/tbt_log_cell.sv
// One squaring step of the log2 chain: yields one fraction bit per cell.
module tbt_log_cell (
   input  logic                 clock,
   input  logic                 en,
   input  tbt_pkg::tbt_log_type d_in,
   output tbt_pkg::tbt_log_type d_out
);

   logic [63:0]          sq;
   logic [32:0]          t;
   tbt_pkg::tbt_log_type d_ff;
   tbt_pkg::tbt_log_type d_in_nxt;

   // Square the mantissa; a carry into bit 32 is the next fraction bit.
   always_comb begin
      sq         = 64'(d_in.m) * 64'(d_in.m);
      t          = sq[63:31];
      d_in_nxt.e = d_in.e;
      d_in_nxt.m = t[32] ? t[32:1] : t[31:0];
      d_in_nxt.f = {d_in.f[tbt_pkg::FRAC_W-2:0], t[32]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_nxt;
      end
   end

   assign d_out = d_ff;

endmodule

// File: rtl/tbt_div_cell.sv
// One restoring division step: yields one quotient bit per cell.
module tbt_div_cell (
   input  logic                 clock,
   input  logic                 en,
   input  tbt_pkg::tbt_div_type d_in,
   output tbt_pkg::tbt_div_type d_out
);

   logic [tbt_pkg::DD_W-1:0] t;
   logic                     ge;
   tbt_pkg::tbt_div_type     d_ff;
   tbt_pkg::tbt_div_type     d_in_nxt;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   always_comb begin
      t            = {d_in.rem[tbt_pkg::DD_W-2:0], d_in.xlo[tbt_pkg::TC_W-1]};
      ge           = (t >= d_in.dvs);
      d_in_nxt.rem = ge ? (t - d_in.dvs) : t;
      d_in_nxt.xlo = {d_in.xlo[tbt_pkg::TC_W-2:0], 1'b0};
      d_in_nxt.q   = {d_in.q[tbt_pkg::TC_W-2:0], ge};
      d_in_nxt.dvs = d_in.dvs;
      d_in_nxt.cap = d_in.cap;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_nxt;
      end
   end

   assign d_out = d_ff;

endmodule

// File: rtl/thermistor_beta_temperature.sv
// Thermistor Beta-equation temperature converter, top level.
//
// Each item is one divider reading; the block returns one temperature in signed
// hundredths of kelvin, Celsius or Fahrenheit, with a status flag for readings
// that imply zero or infinite resistance, or taken while Rb, R0, Beta or T0 is zero.
// The conversion is a pipeline of 58 register stages: one new item is taken every
// cycle while the result is not stalled. The depth is set mostly by two chains of
// cells: 24 squaring cells per operand that produce the log2 fraction bits, and 24
// restoring division cells that form the reciprocal temperature quotient. A stalled
// result holds the whole pipeline. Products derived from the configuration are
// registered: bc100_ff and tb_ff from the settings, then n100_ff from tb_ff.
module thermistor_beta_temperature #(
   parameter int ADC_BITS = tbt_pkg::ADC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // adc_sample
   input  logic [((ADC_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // temperature_centi [17:0], zero filled
   output logic [23:0]                         rsp_tdata,
   // reading_status
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [tbt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tbt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "assert_macros.svh"

   localparam int DEPTH = 10 + tbt_pkg::LOG_STEPS + tbt_pkg::DIV_STEPS;
   localparam int S_NORM = 1;
   localparam int S_LOGE = S_NORM + tbt_pkg::LOG_STEPS;
   localparam int S_SUM  = S_LOGE + 1;
   localparam int S_LN   = S_SUM + 1;
   localparam int S_DD   = S_LN + 1;
   localparam int S_X    = S_DD + 1;
   localparam int S_DIVE = S_X + tbt_pkg::DIV_STEPS;
   localparam int S_TC   = S_DIVE + 1;
   localparam int S_U1   = S_TC + 1;
   localparam int S_U2   = S_U1 + 1;
   localparam int S_OUT  = S_U2 + 1;

   // Configuration registers
   logic [13:0] beta_ff;
   logic [19:0] r0_ff;
   logic [15:0] t0_ff;
   logic [19:0] rb_ff;
   logic        pullup_ff;
   logic [1:0]  unit_ff;
   logic [29:0] tb_ff;
   logic [36:0] n100_ff;
   logic [20:0] bc100_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff   <= 14'd4126;
         r0_ff     <= 20'd10000;
         t0_ff     <= 16'd29815;
         rb_ff     <= 20'd10000;
         pullup_ff <= 1'b1;
         unit_ff   <= tbt_pkg::UNIT_CELSIUS;
      end else if (csr_we) begin
         case (csr_index)
            tbt_pkg::REG_BETA:   beta_ff   <= csr_wdata[13:0];
            tbt_pkg::REG_R0:     r0_ff     <= csr_wdata;
            tbt_pkg::REG_T0:     t0_ff     <= csr_wdata[15:0];
            tbt_pkg::REG_RB:     rb_ff     <= csr_wdata;
            tbt_pkg::REG_PULLUP: pullup_ff <= csr_wdata[0];
            tbt_pkg::REG_UNIT:   unit_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Products of the settings, refreshed every cycle.
   always_ff @(posedge clock) begin
      tb_ff    <= 30'(t0_ff) * 30'(beta_ff);
      n100_ff  <= 37'(tb_ff) * 37'd100;
      bc100_ff <= 21'(beta_ff) * 21'd100;
   end

   // Handshake and control line
   logic                 en;
   tbt_pkg::tbt_ctl_type ctl_ff [DEPTH];
   tbt_pkg::tbt_ctl_type ctl_head;
   logic [ADC_BITS-1:0]  d_smp;
   logic [ADC_BITS:0]    full;

   assign en         = !ctl_ff[DEPTH-1].valid || rsp_tready;
   assign req_tready = en;
   assign full       = (ADC_BITS+1)'(1) << ADC_BITS;
   assign d_smp      = req_tdata[ADC_BITS-1:0];

   always_comb begin
      ctl_head.valid = req_tvalid;
      ctl_head.bad   = (d_smp == '0) || (rb_ff == '0) || (r0_ff == '0) ||
                       (beta_ff == '0) || (t0_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_head;
         for (int i = 1; i < DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // Divider numerator and denominator
   logic [ADC_BITS-1:0] num_ff;
   logic [ADC_BITS-1:0] den_ff;
   logic [ADC_BITS-1:0] diff;

   assign diff = ADC_BITS'(full - (ADC_BITS+1)'(d_smp));

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= pullup_ff ? diff : d_smp;
         den_ff <= pullup_ff ? d_smp : diff;
      end
   end

   // Normalise the four log2 operands: Rb, num, den, R0.
   tbt_pkg::tbt_log_type lg_chain [4][tbt_pkg::LOG_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         lg_chain[0][0] <= tbt_pkg::log_norm(rb_ff);
         lg_chain[1][0] <= tbt_pkg::log_norm(tbt_pkg::LOG_W'(num_ff));
         lg_chain[2][0] <= tbt_pkg::log_norm(tbt_pkg::LOG_W'(den_ff));
         lg_chain[3][0] <= tbt_pkg::log_norm(r0_ff);
      end
   end

   // Rows of squaring cells, one per operand
   for (genvar l = 0; l < 4; l++) begin : g_lane
      for (genvar k = 0; k < tbt_pkg::LOG_STEPS; k++) begin : g_cell
         tbt_log_cell u_cell (
            .clock (clock),
            .en    (en),
            .d_in  (lg_chain[l][k]),
            .d_out (lg_chain[l][k+1])
         );
      end
   end

   // Sum of the logs gives log2(R/R0) in Q.24.
   logic signed [31:0] lq_ff;
   logic signed [31:0] lg_val [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lg_val[l] = $signed({3'b000, lg_chain[l][tbt_pkg::LOG_STEPS].e,
                              lg_chain[l][tbt_pkg::LOG_STEPS].f});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq_ff <= lg_val[0] + lg_val[1] - lg_val[2] - lg_val[3];
      end
   end

   // Scale by ln2 with the magnitude rounded half up.
   logic signed [31:0] lnq_ff;
   logic [30:0]        mag;
   logic [60:0]        ln_prod;
   logic [30:0]        lnmag;

   always_comb begin
      mag     = lq_ff[31] ? 31'(-lq_ff) : lq_ff[30:0];
      ln_prod = 61'(mag) * 61'(tbt_pkg::LN2_Q30) + (61'(1) << 29);
      lnmag   = ln_prod[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lnq_ff <= lq_ff[31] ? -$signed({1'b0, lnmag}) : $signed({1'b0, lnmag});
      end
   end

   // Reciprocal temperature denominator
   logic signed [tbt_pkg::DD_W-1:0] dd_ff;
   logic signed [tbt_pkg::DD_W-1:0] t0_ln;

   assign t0_ln = $signed({1'b0, t0_ff}) * lnq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff <= $signed({3'b000, bc100_ff, 24'd0}) + t0_ln;
      end
   end

   // Rounded dividend, range check and the start of the division chain
   tbt_pkg::tbt_div_type dv_chain [tbt_pkg::DIV_STEPS+1];
   logic [61:0]          xnum;
   logic                 dd_pos;
   logic                 ovf;
   tbt_pkg::tbt_div_type dv_head;

   always_comb begin
      dd_pos      = !dd_ff[tbt_pkg::DD_W-1] && (dd_ff != '0);
      xnum        = (62'(n100_ff) << 24) + 62'(dd_ff[tbt_pkg::DD_W-1:1]);
      ovf         = 72'(xnum) >= {dd_ff, 24'd0};
      dv_head.rem = tbt_pkg::DD_W'(xnum[61:24]);
      dv_head.xlo = xnum[23:0];
      dv_head.q   = '0;
      dv_head.dvs = dd_ff;
      dv_head.cap = ovf || !dd_pos;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_chain[0] <= dv_head;
      end
   end

   for (genvar k = 0; k < tbt_pkg::DIV_STEPS; k++) begin : g_div
      tbt_div_cell u_cell (
         .clock (clock),
         .en    (en),
         .d_in  (dv_chain[k]),
         .d_out (dv_chain[k+1])
      );
   end

   // Temperature in centikelvin, capped
   logic [tbt_pkg::TC_W-1:0] tc_ff;
   tbt_pkg::tbt_div_type     dv_last;

   assign dv_last = dv_chain[tbt_pkg::DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         if (dv_last.cap || dv_last.q > tbt_pkg::TC_CAP) begin
            tc_ff <= tbt_pkg::TC_CAP;
         end else begin
            tc_ff <= dv_last.q;
         end
      end
   end

   // Celsius offset and the Fahrenheit scaling by nine
   logic signed [24:0] sub1_ff;
   logic [24:0]        tc1_ff;
   logic               neg1_ff;
   logic [27:0]        wm2_ff;
   logic signed [24:0] sub_c;
   logic signed [28:0] w9;

   always_comb begin
      sub_c = $signed({1'b0, tc_ff}) - 25'(tbt_pkg::ZERO_C_CK);
      w9    = 29'(sub_c) * 29'sd9;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sub1_ff <= sub_c;
         tc1_ff  <= {1'b0, tc_ff};
         neg1_ff <= w9[28];
         wm2_ff  <= (w9[28] ? 28'(-w9) : w9[27:0]) + 28'd2;
      end
   end

   // Division by five through the reciprocal
   logic signed [24:0] sub2_ff;
   logic [24:0]        tc2_ff;
   logic               neg2_ff;
   logic [25:0]        q5_ff;
   logic [59:0]        r5_prod;

   assign r5_prod = 60'(wm2_ff) * 60'(tbt_pkg::RECIP5);

   always_ff @(posedge clock) begin
      if (en) begin
         sub2_ff <= sub1_ff;
         tc2_ff  <= tc1_ff;
         neg2_ff <= neg1_ff;
         q5_ff   <= r5_prod[59:34];
      end
   end

   // Unit select, saturation and the output register
   logic signed [27:0] v_sel;
   logic signed [27:0] f_val;
   logic [17:0]        temp_ff;
   logic [17:0]        temp_sat;

   always_comb begin
      f_val = (neg2_ff ? -$signed({2'b00, q5_ff}) : $signed({2'b00, q5_ff}))
              + 28'(tbt_pkg::F_OFFSET);
      case (unit_ff)
         tbt_pkg::UNIT_CELSIUS: v_sel = 28'(sub2_ff);
         tbt_pkg::UNIT_FAHR:    v_sel = f_val;
         default:               v_sel = $signed({3'b000, tc2_ff});
      endcase
      if (v_sel > 28'(tbt_pkg::OUT_MAX)) begin
         temp_sat = 18'(tbt_pkg::OUT_MAX);
      end else if (v_sel < 28'(tbt_pkg::OUT_MIN)) begin
         temp_sat = 18'(tbt_pkg::OUT_MIN);
      end else begin
         temp_sat = v_sel[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff <= ctl_ff[S_U2].bad ? '0 : temp_sat;
      end
   end

   assign rsp_tdata  = {6'd0, temp_ff};
   assign rsp_tuser  = ctl_ff[S_OUT].bad;
   assign rsp_tvalid = ctl_ff[S_OUT].valid;

   // Checks on the pipeline
   `TBT_ASSERT_IMP(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser, temp_ff == '0, "invalid reading with nonzero temperature")
   `TBT_ASSERT_IMP(a_range, clock, reset, rsp_tvalid, $signed(temp_ff) <= 18'sd100000 && $signed(temp_ff) >= -18'sd100000, "result outside saturation range")
   `TBT_ASSERT_NXT(a_enter, clock, reset, req_tvalid && req_tready, ctl_ff[0].valid, "accepted item missing from pipeline")
   `TBT_ASSERT_IMP(a_kelvin, clock, reset, rsp_tvalid && !rsp_tuser && unit_ff == tbt_pkg::UNIT_KELVIN, !temp_ff[17], "negative kelvin result")
   `TBT_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, ctl_ff[S_OUT].valid && ctl_ff[S_DIVE].valid == $past(ctl_ff[S_DIVE].valid), "pipeline moved while stalled")

endmodule
